[design/gfrow_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gfrow_pkg
// Shared types, constants and field multiply for the GF(256) row engine.
// ---------------------------------------------------------------------------
package gfrow_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 256;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;

	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_READ = 3'd1;
	localparam logic [2:0] OP_SWAPR = 3'd2;
	localparam logic [2:0] OP_SWAPC = 3'd3;
	localparam logic [2:0] OP_ADD = 3'd4;
	localparam logic [2:0] OP_SCALE = 3'd5;

	localparam logic [0:0] REG_ROWS = 1'd0;
	localparam logic [0:0] REG_COLS = 1'd1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] index_a;
		logic [7:0] index_b;
		logic [7:0] col_index;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic status;
	} rsp_t;

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		logic [2:0] op;
		logic bad;
		logic [ROW_W-1:0] ra;
		logic [ROW_W-1:0] rb;
		logic [COL_W-1:0] ca;
		logic [COL_W-1:0] cb;
		logic [COL_W:0] c0;
		logic [COL_W:0] nc;
		logic [ROW_W:0] nr;
		logic [7:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_RD1, ST_RD2, ST_WR1, ST_WR2, ST_DONE
	} state_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] acc;
		x = a;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) acc = acc ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

[design/gfrow_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gfrow_front
// Holds configuration, range-checks requests and queues classified commands.
// ---------------------------------------------------------------------------
module gfrow_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire gfrow_pkg::req_t req,
	output logic busy,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [8:0] cfg_data,
	output logic cmd_valid,
	output gfrow_pkg::cmd_t cmd,
	input wire logic cmd_pop
);
	import gfrow_pkg::*;

	logic [6:0] row_count_q;
	logic [8:0] col_count_q;
	logic [ROW_W:0] nr;
	logic [COL_W:0] nc;
	cmd_t cmd_d;
	cmd_t q_mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 7'd64;
			col_count_q <= 9'd256;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROWS) row_count_q <= cfg_data[6:0];
			else col_count_q <= cfg_data;
		end
	end

	assign nr = (32'(row_count_q) > MAX_ROWS) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(row_count_q);
	assign nc = (32'(col_count_q) > MAX_COLS) ? (COL_W+1)'(MAX_COLS) : (COL_W+1)'(col_count_q);

	always_comb begin
		logic ia, ib, ica, icb, icc;
		ia = 32'(req.index_a) < 32'(nr);
		ib = 32'(req.index_b) < 32'(nr);
		ica = 32'(req.index_a) < 32'(nc);
		icb = 32'(req.index_b) < 32'(nc);
		icc = 32'(req.col_index) < 32'(nc);
		cmd_d.op = req.req_type;
		cmd_d.ra = req.index_a[ROW_W-1:0];
		cmd_d.rb = req.index_b[ROW_W-1:0];
		cmd_d.ca = req.index_a[COL_W-1:0];
		cmd_d.cb = req.index_b[COL_W-1:0];
		cmd_d.c0 = (COL_W+1)'(req.col_index);
		cmd_d.nc = nc;
		cmd_d.nr = nr;
		cmd_d.value = req.value;
		case (req.req_type)
			OP_WRITE, OP_READ: cmd_d.bad = !(ia && icc);
			OP_SWAPR: cmd_d.bad = !(ia && ib);
			OP_SWAPC: cmd_d.bad = !(ica && icb);
			OP_ADD: cmd_d.bad = !(ia && ib && icc);
			OP_SCALE: cmd_d.bad = !ia;
			default: cmd_d.bad = 1'b1;
		endcase
	end

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= cmd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (cmd_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule
`default_nettype wire

[design/gfrow_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gfrow_back
// Sequencer that carries out queued commands on the byte store.
// ---------------------------------------------------------------------------
module gfrow_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire gfrow_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic done,
	output gfrow_pkg::rsp_t rsp
);
	import gfrow_pkg::*;

	logic [7:0] mem [DEPTH];
	state_t state_q, state_d;
	cmd_t cur_q, cur_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic [COL_W:0] i_q, i_d;
	logic [7:0] x_q, y_q, x_d, y_d;
	logic [7:0] rdata_q;
	logic [ADDR_W-1:0] raddr, waddr;
	logic we;
	logic [7:0] wdata;
	logic [ADDR_W-1:0] addr_x, addr_y;
	logic two;
	logic last;

	// Element pair touched at step i: x always, y for swaps and for the add source.
	always_comb begin
		case (cur_q.op)
			OP_SWAPC: begin
				addr_x = {i_q[ROW_W-1:0], cur_q.ca};
				addr_y = {i_q[ROW_W-1:0], cur_q.cb};
			end
			OP_WRITE, OP_READ: begin
				addr_x = {cur_q.ra, cur_q.c0[COL_W-1:0]};
				addr_y = addr_x;
			end
			default: begin
				addr_x = {cur_q.ra, i_q[COL_W-1:0]};
				addr_y = {cur_q.rb, i_q[COL_W-1:0]};
			end
		endcase
		two = (cur_q.op == OP_SWAPR) || (cur_q.op == OP_SWAPC) || (cur_q.op == OP_ADD);
		last = (cur_q.op == OP_SWAPC) ? (i_q + 1'b1 >= (COL_W+1)'(cur_q.nr))
			: (i_q + 1'b1 >= cur_q.nc);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		i_q <= i_d;
		x_q <= x_d;
		y_q <= y_d;
	end

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		cur_d = cur_q;
		i_d = i_q;
		x_d = x_q;
		y_d = y_q;
		cmd_pop = 1'b0;
		done = 1'b0;
		rsp = '0;
		raddr = addr_x;
		we = 1'b0;
		waddr = addr_x;
		wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cur_d = cmd;
					i_d = (cmd.op == OP_ADD) ? cmd.c0 : '0;
					if (cmd.bad) state_d = ST_DONE;
					else if (cmd.op == OP_WRITE) begin
						we = 1'b1;
						waddr = {cmd.ra, cmd.c0[COL_W-1:0]};
						wdata = cmd.value;
						state_d = ST_DONE;
					end else state_d = ST_RD1;
				end
			end
			ST_RD1: begin
				raddr = addr_x;
				state_d = two ? ST_RD2 : ST_WR1;
			end
			ST_RD2: begin
				raddr = addr_y;
				x_d = rdata_q;
				state_d = ST_WR1;
			end
			ST_WR1: begin
				if (two) y_d = rdata_q;
				else x_d = rdata_q;
				case (cur_q.op)
					OP_READ: state_d = ST_DONE;
					OP_SCALE: begin
						we = 1'b1;
						wdata = gf_mul(rdata_q, cur_q.value);
						if (last) state_d = ST_DONE;
						else begin
							i_d = i_q + 1'b1;
							state_d = ST_RD1;
						end
					end
					OP_ADD: begin
						y_d = gf_mul(rdata_q, cur_q.value);
						state_d = ST_WR2;
					end
					default: begin
						// Swap: y goes into x's slot now, x into y's slot next cycle.
						we = 1'b1;
						waddr = addr_x;
						wdata = rdata_q;
						state_d = ST_WR2;
					end
				endcase
			end
			ST_WR2: begin
				we = 1'b1;
				if (cur_q.op == OP_ADD) begin
					waddr = addr_x;
					wdata = x_q ^ y_q;
				end else begin
					waddr = addr_y;
					wdata = x_q;
				end
				if (last) state_d = ST_DONE;
				else begin
					i_d = i_q + 1'b1;
					state_d = ST_RD1;
				end
			end
			ST_DONE: begin
				done = 1'b1;
				rsp.status = cur_q.bad;
				rsp.read_data = (cur_q.op == OP_READ && !cur_q.bad) ? x_q : 8'h00;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[design/gf256_row_operation_engine.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gf256_row_operation_engine
// GF(256) byte matrix with row and column operations.
// ---------------------------------------------------------------------------
// A write or ignored request needs no store read; a read fetches one element.
// Per column, a row swap reads and writes two, an add (from its start column)
// reads two and writes one, a scale reads and writes one; per row, a column swap
// reads and writes two, all over the store's one read port and one write port.
// One request runs at a time; a two-entry queue takes new requests meanwhile and
// raises busy when full. After reset all 16384 store entries are cleared before
// requests run. Results appear on done for one cycle; the receiver cannot stall.
module gf256_row_operation_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire gfrow_pkg::req_t req,
	output logic busy,
	output logic done,
	output gfrow_pkg::rsp_t rsp,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [8:0] cfg_data
);
	import gfrow_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	gfrow_front u_front (
		.clk, .arst_n, .start, .req, .busy,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.cmd_valid, .cmd, .cmd_pop
	);

	gfrow_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop, .done, .rsp
	);
endmodule
`default_nettype wire

[design/gfrow_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gfrow_checker
// Port-level checks for the row engine.
// ---------------------------------------------------------------------------
module gfrow_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire gfrow_pkg::rsp_t rsp
);
	a_rd_zero_on_bad: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status |-> rsp.read_data == 8'h00) else $error("data on bad");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_reset: assert property (@(posedge clk)
		!arst_n |-> !busy && !done) else $error("busy in reset");
	// The queue only fills up when a request was taken at the previous edge.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without request");
endmodule

bind gf256_row_operation_engine gfrow_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .rsp
);
`default_nettype wire
